@@ src/cfs_pkg.sv @@
// cfs_pkg: shared types, register indexes and the ascii fold function
// for the case-fold substring search block; depends on nothing
`default_nettype none

package cfs_pkg;

    // fold range: only A-Z become a-z
    localparam logic [7:0] FOLD_LO    = 8'h41;
    localparam logic [7:0] FOLD_HI    = 8'h5A;
    localparam logic [7:0] FOLD_DELTA = 8'h20;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_NEEDLE_LOW  = 2'd0;
    localparam cfg_index_t REG_NEEDLE_HIGH = 2'd1;
    localparam cfg_index_t REG_NEEDLE_LEN  = 2'd2;

    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 5;
    localparam int POS_W      = 16;

    typedef struct packed {
        logic [7:0] hay_byte;
        logic       last_byte;
        logic       empty_window;
    } hay_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             too_long;
    } result_t;

    // classified request passed from front to back
    typedef struct packed {
        logic [7:0] octet;
        logic       take;
        logic       close;
    } q_entry_t;

    function automatic logic [7:0] fold_octet(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= FOLD_LO && c <= FOLD_HI)
        begin
            r = c + FOLD_DELTA;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/case_fold_substring_search.sv @@
// case_fold_substring_search: top level tying front, request queue and back
// depends on cfs_pkg, cfs_front, cfs_queue, cfs_back
`default_nettype none

// streaming case-insensitive first-match search. a haystack arrives one
// octet per request on in_*; a request with last_byte set, or with
// empty_window set (no octet), closes the window and one result comes out
// on out_*: found, the start index of the first match (or the byte count
// when nothing matched) and too_long when octets arrived after the count
// saturated at HAY_MAX_LEN. only A-Z fold to a-z, in both needle and
// haystack. the needle (up to NEEDLE_MAX bytes) and its length are written
// through cfg_* at indexes 0 (bytes 0-7), 1 (bytes 8-15) and 2 (length);
// an empty needle always reports found at position 0. the block takes one
// octet per cycle while results drain: the front folds and classifies each
// request in the accepting cycle, a two-entry queue decouples it from the
// back, and the back updates the shift-and vector for all needle positions
// together. a result shows on out_valid in the cycle after the back pops
// its closing request and waits in an output register, while input keeps
// flowing until a second closing request waits at the queue head and the
// queue behind it fills. cfg_ready is always high.
module case_fold_substring_search #(
    parameter int              NEEDLE_MAX  = 16,
    parameter longint unsigned HAY_MAX_LEN = 65535
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire cfs_pkg::hay_item_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output cfs_pkg::result_t                     out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire cfs_pkg::cfg_index_t             cfg_index,
    input  wire logic [cfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cfs_pkg::*;

    localparam int LW = $clog2(NEEDLE_MAX + 1);

    // classified request from the front
    q_entry_t                 front_entry;
    // head of the queue toward the back
    q_entry_t                 q_head;
    logic                     q_valid;
    logic                     q_ready;
    // folded needle and clamped length; the user keeps them static while a window is open, unenforced by the block
    logic [NEEDLE_MAX-1:0][7:0] needle_fold;
    logic [LW-1:0]            used_len;

    cfs_front #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (in_data),
        .entry       (front_entry),
        .needle_fold (needle_fold),
        .used_len    (used_len)
    );

    // the queue's free space decides input acceptance
    cfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (front_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_head)
    );

    cfs_back #(
        .NEEDLE_MAX  (NEEDLE_MAX),
        .HAY_MAX_LEN (HAY_MAX_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_head),
        .needle_fold (needle_fold),
        .used_len    (used_len),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

`ifndef SYNTH
    // input only stalls while the queue holds requests for the back
    a_stall_means_backlog: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_valid
    ) else $error("input stalled with an empty queue");

    // an empty needle always reports a match at position zero
    a_empty_needle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && used_len == '0 && $stable(used_len))
            |-> (out_data.found && out_data.position == '0)
    ) else $error("empty needle result not found at zero");

    // a closing request at the queue head with the output free is taken
    a_close_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        (q_valid && q_head.close && !out_valid) |=> out_valid
    ) else $error("closing request did not produce a result");
`endif

endmodule

`default_nettype wire

@@ src/cfs_front.sv @@
// cfs_front: configuration registers, needle folding and request classification
// depends on cfs_pkg
`default_nettype none

module cfs_front #(
    parameter int NEEDLE_MAX = 16,
    localparam int LW = $clog2(NEEDLE_MAX + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire cfs_pkg::cfg_index_t             cfg_index,
    input  wire logic [cfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire cfs_pkg::hay_item_t              item,
    output cfs_pkg::q_entry_t                    entry,
    output logic [NEEDLE_MAX-1:0][7:0]           needle_fold,
    output logic [LW-1:0]                        used_len
);
    import cfs_pkg::*;

    logic [CFG_DATA_W-1:0] needle_low_reg;
    logic [CFG_DATA_W-1:0] needle_high_reg;
    logic [LEN_REG_W-1:0]  needle_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            needle_len_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NEEDLE_LOW:  needle_low_reg  <= cfg_data;
                REG_NEEDLE_HIGH: needle_high_reg <= cfg_data;
                REG_NEEDLE_LEN:  needle_len_reg  <= cfg_data[LEN_REG_W-1:0];
                default:         ;
            endcase
        end
    end

    // lengths above the maximum clamp to it
    assign used_len = (needle_len_reg > LEN_REG_W'(NEEDLE_MAX)) ? LW'(NEEDLE_MAX)
                                                                 : LW'(needle_len_reg);

    always_comb
    begin
        for (int j = 0; j < NEEDLE_MAX; j++)
        begin
            if (j < 8)
            begin
                needle_fold[j] = fold_octet(needle_low_reg[8*(j%8) +: 8]);
            end
            else
            begin
                needle_fold[j] = fold_octet(needle_high_reg[8*(j%8) +: 8]);
            end
        end
    end

    // an empty-window request carries no octet and closes the window
    always_comb
    begin
        entry.octet = fold_octet(item.hay_byte);
        entry.take  = !item.empty_window;
        entry.close = item.empty_window || item.last_byte;
    end

endmodule

`default_nettype wire

@@ src/cfs_queue.sv @@
// cfs_queue: two-entry queue of classified requests between front and back
// depends on cfs_pkg
`default_nettype none

module cfs_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire cfs_pkg::q_entry_t  push_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output cfs_pkg::q_entry_t       pop_data
);
    import cfs_pkg::*;

    q_entry_t   slot_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wptr_next  = wptr_reg ^ do_push;
        rptr_next  = rptr_reg ^ do_pop;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/cfs_back.sv @@
// cfs_back: shift-and match state, byte count and result register
// depends on cfs_pkg
`default_nettype none

module cfs_back #(
    parameter int              NEEDLE_MAX  = 16,
    parameter longint unsigned HAY_MAX_LEN = 65535,
    localparam int LW = $clog2(NEEDLE_MAX + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    output logic                           q_ready,
    input  wire cfs_pkg::q_entry_t         q_data,
    input  wire logic [NEEDLE_MAX-1:0][7:0] needle_fold,
    input  wire logic [LW-1:0]             used_len,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output cfs_pkg::result_t               out_data
);
    import cfs_pkg::*;

    localparam int CW = $clog2(HAY_MAX_LEN + 64'd1);
    localparam int SW = ((CW > LW) ? CW : LW) + 1;
    localparam int PW = (CW < POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(HAY_MAX_LEN);

    logic [NEEDLE_MAX-1:0] pm_reg;
    logic [NEEDLE_MAX-1:0] pm_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic [CW-1:0]         start_reg;
    logic [CW-1:0]         start_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_reg;
    result_t               out_next;

    logic                  pop;
    logic                  room;
    logic                  accept_octet;
    logic [NEEDLE_MAX-1:0] eq;
    logic [NEEDLE_MAX-1:0] pm_step;
    logic                  full_hit;
    logic [CW-1:0]         start_calc;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign room    = !out_valid_reg || out_ready;
    assign q_ready = !q_data.close || room;
    assign pop     = q_valid && q_ready;

    assign accept_octet = q_data.take && (count_reg < COUNT_LIMIT);
    assign start_calc   = CW'(SW'(count_reg) + SW'(1) - SW'(used_len));

    always_comb
    begin
        eq       = '0;
        full_hit = 1'b0;
        for (int j = 0; j < NEEDLE_MAX; j++)
        begin
            eq[j] = (needle_fold[j] == q_data.octet) && (LW'(j) < used_len);
        end
        pm_step = NEEDLE_MAX'({pm_reg, 1'b1}) & eq;
        for (int j = 0; j < NEEDLE_MAX; j++)
        begin
            if (LW'(j + 1) == used_len)
            begin
                full_hit = pm_step[j];
            end
        end
    end

    always_comb
    begin
        pm_next        = pm_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        start_next     = start_reg;
        ovf_next       = ovf_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (pop)
        begin
            if (accept_octet)
            begin
                pm_next    = pm_step;
                count_next = count_reg + CW'(1);
                if (!seen_reg && full_hit)
                begin
                    seen_next  = 1'b1;
                    start_next = start_calc;
                end
            end
            else if (q_data.take)
            begin
                ovf_next = 1'b1;
            end

            if (q_data.close)
            begin
                out_valid_next    = 1'b1;
                out_next.too_long = ovf_next;
                priority if (used_len == '0)
                begin
                    out_next.found    = 1'b1;
                    out_next.position = '0;
                end
                else if (seen_next)
                begin
                    out_next.found    = 1'b1;
                    out_next.position = POS_W'(start_next[PW-1:0]);
                end
                else
                begin
                    out_next.found    = 1'b0;
                    out_next.position = POS_W'(count_next[PW-1:0]);
                end
                // window state clears for the next window
                pm_next    = '0;
                count_next = '0;
                seen_next  = 1'b0;
                start_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg        <= '0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            start_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pm_reg        <= pm_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            start_reg     <= start_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire
